// ----- src/tsp_pkg.sv -----
// tone sequence player package: sizes, entry codes, sequencer states and store port struct
// no dependencies
package tsp_pkg;

  localparam int unsigned SEQ_DEPTH   = 16;
  localparam int unsigned GAP_TICKS   = 10;
  localparam int unsigned BEEP_CODE   = 1;
  localparam int unsigned REPEAT_CODE = 2;

  localparam int unsigned IDX_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int unsigned POS_W = $clog2(SEQ_DEPTH + 1);
  localparam int unsigned GAP_W = (GAP_TICKS > 0) ? $clog2(GAP_TICKS + 1) : 1;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned ARG_W  = 14;

  localparam logic [1:0] CMD_BEEP   = BEEP_CODE[1:0];
  localparam logic [1:0] CMD_REPEAT = REPEAT_CODE[1:0];

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [ARG_W-1:0] REP_MAX = {ARG_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_EVAL,
    S_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } store_req_t;

endpackage

// ----- src/tone_sequence_player_unit.sv -----
// tone sequence player top level: command decode, entry walk sequencer, output register
// depends on tsp_pkg and tsp_store
//
//  channel | ports                                      | direction | role
//  --------+--------------------------------------------+-----------+------------------------
//  in      | in_valid in_ready in_func in_entry_index    | input     | write, start or tick
//          | in_entry_word                              |           |
//  out     | out_valid out_ready out_tone_on            | output    | tone state after each
//          | out_tone_freq_hz out_busy_res              |           | input transaction
//
// one input transaction at a time: a write, or a tick inside a wait, goes from idle to done,
// and every entry read from the store passes a walk state (memory read) and then an evaluate
// state, so a tick that reaches an entry walks, evaluates and completes in done, and a chain
// of zero-duration entries repeats walk and evaluate for each entry through the single read port
// reset is synchronous, active low; the store valid bits clear at once, no clearing pass
// a result waiting on out_ready does not block the next input transaction; only the
// following result waits for the output register to free up
module tone_sequence_player_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_entry_index,
  input  logic [31:0] in_entry_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tone_on,
  output logic [13:0] out_tone_freq_hz,
  output logic        out_busy_res
);
  import tsp_pkg::*;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [DUR_W-1:0]  rem_r, rem_nxt;
  logic [ARG_W-1:0]  rep_r, rep_nxt;
  logic              again_r, again_nxt;
  logic [GAP_W-1:0]  gap_r, gap_nxt;
  logic              running_r, running_nxt;
  logic              tone_on_r, tone_on_nxt;
  logic [ARG_W-1:0]  freq_r, freq_nxt;
  logic              allow_r, allow_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_tone_on_r;
  logic [ARG_W-1:0]  out_freq_r;
  logic              out_busy_r;
  logic              out_load;

  store_req_t        st_req;
  logic [WORD_W-1:0] rd_word;

  logic              in_fire;
  logic              pos_in_seq;
  logic [DUR_W-1:0]  rem_dec;
  logic [GAP_W-1:0]  gap_dec;
  logic [1:0]        ev_cmd;
  logic [DUR_W-1:0]  ev_dur;
  logic [ARG_W-1:0]  ev_arg;

  tsp_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (st_req),
    .rd_word (rd_word)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign pos_in_seq = (pos_r < POS_W'(SEQ_DEPTH));
  assign rem_dec    = (rem_r != '0) ? rem_r - DUR_W'(1) : '0;
  assign gap_dec    = (gap_r != '0) ? gap_r - GAP_W'(1) : '0;

  // packed entry fields
  assign ev_cmd = rd_word[1:0];
  assign ev_dur = rd_word[2 +: DUR_W];
  assign ev_arg = rd_word[2 + DUR_W +: ARG_W];

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    rep_nxt     = rep_r;
    again_nxt   = again_r;
    gap_nxt     = gap_r;
    running_nxt = running_r;
    tone_on_nxt = tone_on_r;
    freq_nxt    = freq_r;
    allow_nxt   = allow_r;
    out_load    = 1'b0;

    st_req.wr_en   = 1'b0;
    st_req.wr_addr = IDX_W'(in_entry_index);
    st_req.wr_data = in_entry_word;
    st_req.rd_en   = 1'b0;
    st_req.rd_addr = pos_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DONE;
          priority if (in_func == FUNC_WRITE) begin
            // slots past the store depth are dropped
            st_req.wr_en = (32'(in_entry_index) < SEQ_DEPTH);
          end else if (in_func == FUNC_START) begin
            running_nxt = 1'b1;
            rep_nxt     = '0;
            again_nxt   = 1'b0;
            pos_nxt     = '0;
            rem_nxt     = '0;
            gap_nxt     = '0;
            allow_nxt   = 1'b0;
            state_nxt   = S_WALK;
          end else if (in_func == FUNC_TICK && running_r) begin
            if (pos_in_seq) begin
              rem_nxt = rem_dec;
              if (rem_dec == '0) begin
                // wait over, move on and let one new pass begin
                pos_nxt   = pos_r + POS_W'(1);
                allow_nxt = 1'b1;
                state_nxt = S_WALK;
              end
            end else begin
              gap_nxt = gap_dec;
              if (gap_dec == '0) begin
                if (again_r) begin
                  again_nxt = 1'b0;
                  pos_nxt   = '0;
                  allow_nxt = 1'b0;
                  state_nxt = S_WALK;
                end else begin
                  running_nxt = 1'b0;
                end
              end
            end
          end else begin
            // idle tick or unused func code: state unchanged
          end
        end
      end
      S_WALK: begin
        if (pos_in_seq) begin
          st_req.rd_en = 1'b1;
          state_nxt    = S_EVAL;
        end else begin
          state_nxt = S_END;
        end
      end
      S_EVAL: begin
        if (rd_word == '0) begin
          state_nxt = S_END;
        end else begin
          priority if (ev_cmd == CMD_REPEAT) begin
            if (ev_arg == '0 || rep_r < ev_arg) begin
              if (rep_r != REP_MAX) begin
                rep_nxt = rep_r + ARG_W'(1);
              end
              again_nxt = 1'b1;
            end
          end else if (ev_cmd == CMD_BEEP && ev_arg != '0) begin
            freq_nxt    = ev_arg;
            tone_on_nxt = 1'b1;
          end else begin
            tone_on_nxt = 1'b0;
          end
          if (ev_dur != '0) begin
            rem_nxt   = ev_dur;
            state_nxt = S_DONE;
          end else begin
            pos_nxt   = pos_r + POS_W'(1);
            state_nxt = S_WALK;
          end
        end
      end
      S_END: begin
        // pass finished: silence, park in the gap
        tone_on_nxt = 1'b0;
        pos_nxt     = POS_W'(SEQ_DEPTH);
        rem_nxt     = '0;
        gap_nxt     = GAP_W'(GAP_TICKS);
        state_nxt   = S_DONE;
        if (GAP_TICKS == 0) begin
          if (!again_r) begin
            running_nxt = 1'b0;
          end else if (allow_r) begin
            // zero gap: at most one extra pass per transaction
            allow_nxt = 1'b0;
            again_nxt = 1'b0;
            pos_nxt   = '0;
            state_nxt = S_WALK;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      rem_r       <= '0;
      rep_r       <= '0;
      again_r     <= 1'b0;
      gap_r       <= '0;
      running_r   <= 1'b0;
      tone_on_r   <= 1'b0;
      freq_r      <= '0;
      allow_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
      rep_r       <= rep_nxt;
      again_r     <= again_nxt;
      gap_r       <= gap_nxt;
      running_r   <= running_nxt;
      tone_on_r   <= tone_on_nxt;
      freq_r      <= freq_nxt;
      allow_r     <= allow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, captured when the transaction completes
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tone_on_r <= tone_on_r;
      out_freq_r    <= freq_r;
      out_busy_r    <= running_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tone_on      = out_tone_on_r;
  assign out_tone_freq_hz = out_freq_r;
  assign out_busy_res     = out_busy_r;

`ifndef SYNTHESIS
  a_write_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_WRITE) |=> (state_r == S_DONE))
    else $error("write transaction did not complete in one cycle");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(SEQ_DEPTH))
    else $error("position beyond the gap marker");

  a_silent_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> !tone_on_r)
    else $error("tone on while playback idle");

  a_gap_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == POS_W'(SEQ_DEPTH)) |-> (rem_r == '0))
    else $error("entry wait left over in the gap");
`endif

endmodule

// ----- src/tsp_store.sv -----
// entry store: synchronous single-write, single-read memory with a registered read
// per-entry valid bits make never-written entries read as zero; depends on tsp_pkg
module tsp_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tsp_pkg::store_req_t       req,
  output logic [tsp_pkg::WORD_W-1:0] rd_word
);
  import tsp_pkg::*;

  logic [WORD_W-1:0]    mem [SEQ_DEPTH];
  logic [SEQ_DEPTH-1:0] vld_r;
  logic [WORD_W-1:0]    rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  // entry cleared by reset reads as an end marker
  assign rd_word = rd_vld_r ? rd_data_r : '0;

endmodule
